// ----- rtl/fgs_pkg.sv -----
package fgs_pkg;

  localparam int CMD_W   = 2;
  localparam int COORD_W = 5;
  localparam int KIND_W  = 3;
  localparam int SLOT_W  = 10;
  localparam int COUNT_W = 11;
  localparam int CELL_W  = 11;

  localparam logic [CELL_W-1:0]  EMPTY_CODE = '1;
  localparam logic [COUNT_W-1:0] SLOT_LIMIT = COUNT_W'(1024);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_DOWN  = 2'd1,
    CMD_UP    = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    K_PLACED   = 3'd0,
    K_OCCUPIED = 3'd1,
    K_FULL     = 3'd2,
    K_MOVED    = 3'd3,
    K_NONE     = 3'd4,
    K_CLEARED  = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_CHK,
    S_RD_D,
    S_CHK_D,
    S_CHK_G1,
    S_CHK_G2,
    S_WR_SRC,
    S_END,
    S_REPLY
  } state_t;

endpackage

// ----- rtl/falling_grain_grid_sweep.sv -----
// channel | ports                                              | direction
// --------+----------------------------------------------------+----------
// in      | in_valid, in_stall, in_command, in_cell_x, in_cell_y | into block
// out     | out_valid, out_stall, out_kind, out_slot, out_dest_x, | out of block
//         | out_dest_y, out_grain_count, out_last              |
//
// one word at a time; a sweep visits the rows of the column in order, one memory read per
// cycle while no move waits on the output
// reset writes all GRID_WIDTH*GRID_HEIGHT cells (1024 by default) empty, and so does clear,
// which then replies; no word is taken meanwhile
// a stalled output holds the block in a step that loads a result; the next word is taken once
// the last result of the current one sits in the output register
module falling_grain_grid_sweep #(
  parameter int GRID_WIDTH  = 32,
  parameter int GRID_HEIGHT = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [fgs_pkg::CMD_W-1:0]    in_command,
  input  logic [fgs_pkg::COORD_W-1:0]  in_cell_x,
  input  logic [fgs_pkg::COORD_W-1:0]  in_cell_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fgs_pkg::KIND_W-1:0]   out_kind,
  output logic [fgs_pkg::SLOT_W-1:0]   out_slot,
  output logic [fgs_pkg::COORD_W-1:0]  out_dest_x,
  output logic [fgs_pkg::COORD_W-1:0]  out_dest_y,
  output logic [fgs_pkg::COUNT_W-1:0]  out_grain_count,
  output logic                         out_last
);

  import fgs_pkg::*;

  localparam int DEPTH  = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int XW     = $clog2(GRID_WIDTH);
  localparam int YW     = $clog2(GRID_HEIGHT);

  localparam logic [ADDR_W-1:0] HEIGHT_A   = ADDR_W'(GRID_HEIGHT);
  localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(DEPTH - 1);
  localparam logic [XW-1:0]     COL_LAST   = XW'(GRID_WIDTH - 1);
  localparam logic [YW-1:0]     ROW_LAST   = YW'(GRID_HEIGHT - 1);
  localparam logic [YW-1:0]     ROW_UP_TOP = YW'(GRID_HEIGHT - 2);
  localparam logic [YW-1:0]     ROW_ONE    = YW'(1);

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [XW-1:0] cx,
                                                  input logic [YW-1:0] cy);
    return ADDR_W'(cx) * HEIGHT_A + ADDR_W'(cy);
  endfunction

  state_t state_r, state_nxt;

  logic [CELL_W-1:0] cell_mem_r [DEPTH];
  logic [CELL_W-1:0] rd_data_r;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;

  logic [XW-1:0]      x_r, x_nxt;
  logic [YW-1:0]      y_r, y_nxt;
  logic [XW-1:0]      tcol_r, tcol_nxt;
  logic               down_r, down_nxt;
  logic [CELL_W-1:0]  src_r, src_nxt;
  logic [COUNT_W-1:0] next_slot_r, next_slot_nxt;
  logic [ADDR_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic               report_r, report_nxt;
  kind_t              reply_kind_r, reply_kind_nxt;

  logic               pend_valid_r, pend_valid_nxt;
  logic [SLOT_W-1:0]  pend_slot_r, pend_slot_nxt;
  logic [XW-1:0]      pend_x_r, pend_x_nxt;
  logic [YW-1:0]      pend_y_r, pend_y_nxt;

  logic               out_valid_r, out_valid_nxt;
  kind_t              out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [COORD_W-1:0] out_dest_x_r, out_dest_x_nxt;
  logic [COORD_W-1:0] out_dest_y_r, out_dest_y_nxt;
  logic [COUNT_W-1:0] out_grain_count_r, out_grain_count_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_load;

  logic          out_free;
  logic          push_ok;
  logic          cell_empty;
  logic          in_x_ok;
  logic          in_y_ok;
  logic          row_last;
  logic          has_g2;
  logic [YW-1:0] ty;
  logic [YW-1:0] y_step;
  logic [XW-1:0] g1_col;
  logic [XW-1:0] tgt_col;
  logic [XW-1:0] in_x;
  logic [YW-1:0] in_y;
  logic [YW-1:0] start_y;

  assign out_free   = !out_valid_r || !out_stall;
  assign push_ok    = !pend_valid_r || out_free;
  assign cell_empty = (rd_data_r == EMPTY_CODE);
  assign in_x_ok    = (32'(in_cell_x) < GRID_WIDTH);
  assign in_y_ok    = (32'(in_cell_y) < GRID_HEIGHT);
  assign in_x       = XW'(in_cell_x);
  assign in_y       = YW'(in_cell_y);
  assign start_y    = (in_command == CMD_DOWN) ? ROW_ONE : ROW_UP_TOP;
  assign row_last   = down_r ? (y_r == ROW_LAST) : (y_r == '0);
  assign ty         = down_r ? y_r - 1'b1 : y_r + 1'b1;
  assign y_step     = down_r ? y_r + 1'b1 : y_r - 1'b1;
  assign g1_col     = (x_r == '0) ? x_r + 1'b1 : x_r - 1'b1;
  assign has_g2     = (x_r != '0) && (x_r != COL_LAST);
  assign tgt_col    = (state_r == S_CHK_D) ? x_r : tcol_r;

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_slot        = out_slot_r;
  assign out_dest_x      = out_dest_x_r;
  assign out_dest_y      = out_dest_y_r;
  assign out_grain_count = out_grain_count_r;
  assign out_last        = out_last_r;

  // cell memory, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cell_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= cell_mem_r[rd_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_idx_r == ADDR_LAST) begin
          state_nxt = report_r ? S_REPLY : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_command)
            CMD_ADD:          state_nxt = (in_x_ok && in_y_ok) ? S_ADD_CHK : S_REPLY;
            CMD_DOWN, CMD_UP: state_nxt = in_x_ok ? S_RD_D : S_END;
            CMD_CLEAR:        state_nxt = S_CLEAR;
            default:          state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_CHK: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD_D: begin
        if (cell_empty) begin
          state_nxt = row_last ? S_END : S_RD_D;
        end else begin
          state_nxt = S_CHK_D;
        end
      end
      S_CHK_D, S_CHK_G1, S_CHK_G2: begin
        if (cell_empty) begin
          if (push_ok) begin
            state_nxt = S_WR_SRC;
          end
        end else if (state_r == S_CHK_D) begin
          state_nxt = S_CHK_G1;
        end else if (state_r == S_CHK_G1 && has_g2) begin
          state_nxt = S_CHK_G2;
        end else begin
          state_nxt = row_last ? S_END : S_RD_D;
        end
      end
      S_WR_SRC: begin
        state_nxt = row_last ? S_END : S_RD_D;
      end
      S_END, S_REPLY: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    x_nxt               = x_r;
    y_nxt               = y_r;
    tcol_nxt            = tcol_r;
    down_nxt            = down_r;
    src_nxt             = src_r;
    next_slot_nxt       = next_slot_r;
    clr_idx_nxt         = clr_idx_r;
    report_nxt          = report_r;
    reply_kind_nxt      = reply_kind_r;
    pend_valid_nxt      = pend_valid_r;
    pend_slot_nxt       = pend_slot_r;
    pend_x_nxt          = pend_x_r;
    pend_y_nxt          = pend_y_r;
    rd_en               = 1'b0;
    rd_addr             = cell_addr(x_r, y_step);
    wr_en               = 1'b0;
    wr_addr             = clr_idx_r;
    wr_data             = EMPTY_CODE;
    out_load            = 1'b0;
    out_kind_nxt        = K_NONE;
    out_slot_nxt        = '0;
    out_dest_x_nxt      = '0;
    out_dest_y_nxt      = '0;
    out_grain_count_nxt = next_slot_r;
    out_last_nxt        = 1'b1;

    unique case (state_r)
      S_CLEAR: begin
        wr_en       = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == ADDR_LAST) begin
          reply_kind_nxt = K_CLEARED;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          x_nxt = in_x;
          unique case (in_command)
            CMD_ADD: begin
              y_nxt          = in_y;
              reply_kind_nxt = K_OCCUPIED;
              rd_en          = in_x_ok && in_y_ok;
              rd_addr        = cell_addr(in_x, in_y);
            end
            CMD_DOWN, CMD_UP: begin
              down_nxt = (in_command == CMD_DOWN);
              y_nxt    = start_y;
              rd_en    = in_x_ok;
              rd_addr  = cell_addr(in_x, start_y);
            end
            CMD_CLEAR: begin
              next_slot_nxt = '0;
              clr_idx_nxt   = '0;
              report_nxt    = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_ADD_CHK: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!cell_empty) begin
            out_kind_nxt = K_OCCUPIED;
          end else if (next_slot_r >= SLOT_LIMIT) begin
            out_kind_nxt = K_FULL;
          end else begin
            wr_en               = 1'b1;
            wr_addr             = cell_addr(x_r, y_r);
            wr_data             = CELL_W'(next_slot_r);
            next_slot_nxt       = next_slot_r + 1'b1;
            out_kind_nxt        = K_PLACED;
            out_slot_nxt        = next_slot_r[SLOT_W-1:0];
            out_dest_x_nxt      = COORD_W'(x_r);
            out_dest_y_nxt      = COORD_W'(y_r);
            out_grain_count_nxt = next_slot_r + 1'b1;
          end
        end
      end
      S_RD_D: begin
        if (cell_empty) begin
          y_nxt = y_step;
          rd_en = !row_last;
        end else begin
          src_nxt = rd_data_r;
          rd_en   = 1'b1;
          rd_addr = cell_addr(x_r, ty);
        end
      end
      S_CHK_D, S_CHK_G1, S_CHK_G2: begin
        if (cell_empty) begin
          if (push_ok) begin
            // grain moves; the previous move goes out, this one waits for last
            wr_en          = 1'b1;
            wr_addr        = cell_addr(tgt_col, ty);
            wr_data        = src_r;
            out_load       = pend_valid_r;
            out_kind_nxt   = K_MOVED;
            out_slot_nxt   = pend_slot_r;
            out_dest_x_nxt = COORD_W'(pend_x_r);
            out_dest_y_nxt = COORD_W'(pend_y_r);
            out_last_nxt   = 1'b0;
            pend_valid_nxt = 1'b1;
            pend_slot_nxt  = src_r[SLOT_W-1:0];
            pend_x_nxt     = tgt_col;
            pend_y_nxt     = ty;
          end
        end else if (state_r == S_CHK_D) begin
          tcol_nxt = g1_col;
          rd_en    = 1'b1;
          rd_addr  = cell_addr(g1_col, ty);
        end else if (state_r == S_CHK_G1 && has_g2) begin
          tcol_nxt = x_r + 1'b1;
          rd_en    = 1'b1;
          rd_addr  = cell_addr(x_r + 1'b1, ty);
        end else begin
          y_nxt = y_step;
          rd_en = !row_last;
        end
      end
      S_WR_SRC: begin
        wr_en   = 1'b1;
        wr_addr = cell_addr(x_r, y_r);
        y_nxt   = y_step;
        rd_en   = !row_last;
      end
      S_END: begin
        if (out_free) begin
          out_load       = 1'b1;
          pend_valid_nxt = 1'b0;
          if (pend_valid_r) begin
            out_kind_nxt   = K_MOVED;
            out_slot_nxt   = pend_slot_r;
            out_dest_x_nxt = COORD_W'(pend_x_r);
            out_dest_y_nxt = COORD_W'(pend_y_r);
          end
        end
      end
      S_REPLY: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_nxt = reply_kind_r;
        end
      end
      default: ;
    endcase

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      report_r     <= 1'b0;
      next_slot_r  <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      report_r     <= report_nxt;
      next_slot_r  <= next_slot_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    tcol_r       <= tcol_nxt;
    down_r       <= down_nxt;
    src_r        <= src_nxt;
    reply_kind_r <= reply_kind_nxt;
    pend_slot_r  <= pend_slot_nxt;
    pend_x_r     <= pend_x_nxt;
    pend_y_r     <= pend_y_nxt;
    if (out_load) begin
      out_kind_r        <= out_kind_nxt;
      out_slot_r        <= out_slot_nxt;
      out_dest_x_r      <= out_dest_x_nxt;
      out_dest_y_r      <= out_dest_y_nxt;
      out_grain_count_r <= out_grain_count_nxt;
      out_last_r        <= out_last_nxt;
    end
  end

endmodule

// ----- bench/falling_grain_grid_sweep_tb.sv -----
`timescale 1ns / 1ps

module falling_grain_grid_sweep_tb;
  import fgs_pkg::*;

  localparam int GW = 32;
  localparam int GH = 32;
  localparam int PLAN_ROWS = 24;
  localparam int RANDOM_WORDS = 88;
  localparam int QUIET_LIMIT = 8000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    kind_t               kind;
    logic [SLOT_W-1:0]   slot;
    logic [COORD_W-1:0]  dest_x;
    logic [COORD_W-1:0]  dest_y;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } report_t;

  typedef struct {
    cmd_t                cmd;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    bit                  typed;
    kind_t               kind;
    logic [SLOT_W-1:0]   slot;
    logic [COORD_W-1:0]  dx;
    logic [COORD_W-1:0]  dy;
    logic [COUNT_W-1:0]  count;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   in_command = CMD_ADD;
  logic [COORD_W-1:0] in_cell_x = '0;
  logic [COORD_W-1:0] in_cell_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [KIND_W-1:0]  out_kind;
  logic [SLOT_W-1:0]  out_slot;
  logic [COORD_W-1:0] out_dest_x;
  logic [COORD_W-1:0] out_dest_y;
  logic [COUNT_W-1:0] out_grain_count;
  logic               out_last;

  logic [CELL_W-1:0]  grid [GW][GH];
  logic [COUNT_W-1:0] next_slot;
  report_t            fresh[$];
  report_t            awaited[$];
  plan_row_t          plan [PLAN_ROWS];
  int                 errors = 0;
  int                 quiet = 0;
  bit                 calm = 1'b0;
  bit                 hold_req = 1'b0;

  falling_grain_grid_sweep #(
    .GRID_WIDTH(GW),
    .GRID_HEIGHT(GH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_cell_x(in_cell_x),
    .in_cell_y(in_cell_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_slot(out_slot),
    .out_dest_x(out_dest_x),
    .out_dest_y(out_dest_y),
    .out_grain_count(out_grain_count),
    .out_last(out_last)
  );

  always #2 clk = ~clk;

  function automatic report_t mk_report(kind_t k, logic [SLOT_W-1:0] s,
                                        logic [COORD_W-1:0] dx, logic [COORD_W-1:0] dy);
    report_t r;
    r.kind = k;
    r.slot = s;
    r.dest_x = dx;
    r.dest_y = dy;
    r.count = next_slot;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic empty_grid();
    foreach (grid[i, j]) grid[i][j] = EMPTY_CODE;
    next_slot = '0;
  endtask

  task automatic shift_grain(input int sx, input int sy, input int tx, input int ty,
                             output bit moved);
    moved = 1'b0;
    if (grid[tx][ty] == EMPTY_CODE) begin
      grid[tx][ty] = grid[sx][sy];
      grid[sx][sy] = EMPTY_CODE;
      fresh.push_back(mk_report(K_MOVED, grid[tx][ty][SLOT_W-1:0], COORD_W'(tx),
                                COORD_W'(ty)));
      moved = 1'b1;
    end
  endtask

  // fills fresh with the words that one command produces
  task automatic step_grid(input cmd_t cmd, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y);
    bit moved;
    bit down;
    int xi;
    int row;
    int dst;
    fresh.delete();
    xi = int'(x);
    case (cmd)
      CMD_ADD: begin
        if (grid[x][y] != EMPTY_CODE) begin
          fresh.push_back(mk_report(K_OCCUPIED, '0, '0, '0));
        end else if (next_slot >= SLOT_LIMIT) begin
          fresh.push_back(mk_report(K_FULL, '0, '0, '0));
        end else begin
          grid[x][y] = next_slot;
          next_slot = next_slot + 1'b1;
          fresh.push_back(mk_report(K_PLACED, grid[x][y][SLOT_W-1:0], x, y));
        end
      end
      CMD_CLEAR: begin
        empty_grid();
        fresh.push_back(mk_report(K_CLEARED, '0, '0, '0));
      end
      default: begin
        down = (cmd == CMD_DOWN);
        for (int i = 0; i < GH - 1; i++) begin
          row = down ? i + 1 : GH - 2 - i;
          dst = down ? row - 1 : row + 1;
          if (grid[xi][row] == EMPTY_CODE) continue;
          shift_grain(xi, row, xi, dst, moved);
          if (!moved && xi != 0) shift_grain(xi, row, xi - 1, dst, moved);
          if (!moved && xi != GW - 1) shift_grain(xi, row, xi + 1, dst, moved);
        end
        if (fresh.size() == 0) fresh.push_back(mk_report(K_NONE, '0, '0, '0));
      end
    endcase
    fresh[fresh.size() - 1].last = 1'b1;
  endtask

  task automatic send_word(input cmd_t cmd, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input bit typed,
                           input report_t given);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_cell_x <= x;
    in_cell_y <= y;
    do @(posedge clk); while (in_stall !== 1'b0);
    step_grid(cmd, x, y);
    if (typed) begin
      awaited.push_back(given);
    end else begin
      foreach (fresh[i]) awaited.push_back(fresh[i]);
    end
  endtask

  always @(posedge clk) begin : monitor
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        $error("unexpected word: kind %0d slot %0d", out_kind, out_slot);
        errors++;
      end else begin
        want = awaited.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_kind);
          errors++;
        end
        if (out_slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_slot);
          errors++;
        end
        if (out_dest_x !== want.dest_x) begin
          $error("dest_x: expected %0d, got %0d", want.dest_x, out_dest_x);
          errors++;
        end
        if (out_dest_y !== want.dest_y) begin
          $error("dest_y: expected %0d, got %0d", want.dest_y, out_dest_y);
          errors++;
        end
        if (out_grain_count !== want.count) begin
          $error("grain_count: expected %0d, got %0d", want.count, out_grain_count);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("[falling_grain_grid_sweep] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int span;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long hold so the result side backs up into the input
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        span = $urandom_range(1, 16);
        repeat (span) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    report_t              given;
    cmd_t                 cmd;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    int                   pick;
    int                   zone;
    empty_grid();
    plan = '{
      '{CMD_DOWN,  5'd3,  5'd0,  1'b1, K_NONE,     10'd0,  5'd0,  5'd0,  11'd0},
      '{CMD_ADD,   5'd0,  5'd0,  1'b1, K_PLACED,   10'd0,  5'd0,  5'd0,  11'd1},
      '{CMD_ADD,   5'd0,  5'd0,  1'b1, K_OCCUPIED, 10'd0,  5'd0,  5'd0,  11'd1},
      '{CMD_ADD,   5'd31, 5'd31, 1'b1, K_PLACED,   10'd1,  5'd31, 5'd31, 11'd2},
      '{CMD_ADD,   5'd0,  5'd31, 1'b1, K_PLACED,   10'd2,  5'd0,  5'd31, 11'd3},
      '{CMD_ADD,   5'd0,  5'd1,  1'b1, K_PLACED,   10'd3,  5'd0,  5'd1,  11'd4},
      '{CMD_ADD,   5'd1,  5'd0,  1'b1, K_PLACED,   10'd4,  5'd1,  5'd0,  11'd5},
      '{CMD_DOWN,  5'd0,  5'd0,  1'b0, K_NONE,     10'd0,  5'd0,  5'd0,  11'd0},
      '{CMD_UP,    5'd31, 5'd0,  1'b0, K_NONE,     10'd0,  5'd0,  5'd0,  11'd0},
      '{CMD_ADD,   5'd15, 5'd1,  1'b1, K_PLACED,   10'd5,  5'd15, 5'd1,  11'd6},
      '{CMD_ADD,   5'd15, 5'd0,  1'b1, K_PLACED,   10'd6,  5'd15, 5'd0,  11'd7},
      '{CMD_ADD,   5'd14, 5'd0,  1'b1, K_PLACED,   10'd7,  5'd14, 5'd0,  11'd8},
      '{CMD_DOWN,  5'd15, 5'd21, 1'b0, K_NONE,     10'd0,  5'd0,  5'd0,  11'd0},
      '{CMD_ADD,   5'd20, 5'd1,  1'b1, K_PLACED,   10'd8,  5'd20, 5'd1,  11'd9},
      '{CMD_ADD,   5'd20, 5'd0,  1'b1, K_PLACED,   10'd9,  5'd20, 5'd0,  11'd10},
      '{CMD_DOWN,  5'd20, 5'd10, 1'b0, K_NONE,     10'd0,  5'd0,  5'd0,  11'd0},
      '{CMD_ADD,   5'd31, 5'd1,  1'b1, K_PLACED,   10'd10, 5'd31, 5'd1,  11'd11},
      '{CMD_ADD,   5'd31, 5'd0,  1'b1, K_PLACED,   10'd11, 5'd31, 5'd0,  11'd12},
      '{CMD_DOWN,  5'd31, 5'd0,  1'b0, K_NONE,     10'd0,  5'd0,  5'd0,  11'd0},
      '{CMD_UP,    5'd0,  5'd0,  1'b0, K_NONE,     10'd0,  5'd0,  5'd0,  11'd0},
      '{CMD_UP,    5'd15, 5'd0,  1'b0, K_NONE,     10'd0,  5'd0,  5'd0,  11'd0},
      '{CMD_CLEAR, 5'd7,  5'd9,  1'b1, K_CLEARED,  10'd0,  5'd0,  5'd0,  11'd0},
      '{CMD_ADD,   5'd31, 5'd31, 1'b1, K_PLACED,   10'd0,  5'd31, 5'd31, 11'd1},
      '{CMD_UP,    5'd31, 5'd0,  1'b0, K_NONE,     10'd0,  5'd0,  5'd0,  11'd0}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      given.kind = plan[i].kind;
      given.slot = plan[i].slot;
      given.dest_x = plan[i].dx;
      given.dest_y = plan[i].dy;
      given.count = plan[i].count;
      given.last = 1'b1;
      send_word(plan[i].cmd, plan[i].x, plan[i].y, plan[i].typed, given);
    end

    // clustered coordinates so grains stack and slide
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      calm = (k >= RANDOM_WORDS - 20);
      if (k == 30) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 3) cmd = CMD_CLEAR;
      else if (pick < 55) cmd = CMD_ADD;
      else if (pick < 78) cmd = CMD_DOWN;
      else cmd = CMD_UP;
      zone = $urandom_range(0, 3);
      case (zone)
        0: x = COORD_W'($urandom_range(0, 3));
        1: x = COORD_W'($urandom_range(28, 31));
        2: x = COORD_W'($urandom_range(12, 16));
        default: x = COORD_W'($urandom());
      endcase
      if ($urandom_range(0, 3) == 0) y = COORD_W'($urandom());
      else if ($urandom_range(0, 1) == 1) y = COORD_W'($urandom_range(0, 5));
      else y = COORD_W'($urandom_range(26, 31));
      send_word(cmd, x, y, 1'b0, given);
    end
    in_valid <= 1'b0;

    while (awaited.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("[falling_grain_grid_sweep] OK");
    end else begin
      $display("[falling_grain_grid_sweep] ERROR");
    end
    $finish;
  end

endmodule
